>>> src/crc_fe_pkg.sv
package crc_fe_pkg;

    localparam int DEF_MAX_ID_LEN      = 64;
    localparam int DEF_MAX_PAYLOAD_LEN = 256;

    localparam logic [7:0]  FRAME_STX      = 8'h02;
    localparam logic [7:0]  FRAME_ETX      = 8'h03;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CRC_SEED_RESET = 16'hFFFF;
    localparam logic [15:0] LEN_OVERHEAD   = 16'd6;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic [1:0] ST_FRAME  = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_STRAY  = 2'd2;

    localparam int STEP_W = 3;

    typedef struct packed {
        logic        command;
        logic [7:0]  msg_type;
        logic [7:0]  reader_id_len;
        logic [15:0] pay_len;
        logic [7:0]  data_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       frame_end;
        logic       run_last;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> src/crc_framed_event_encoder.sv
// Event frame encoder: STX, little-endian length, body, CRC-16 (low byte first), ETX.
// Input channel (i_valid / o_stall): one command per transfer, either a start with
// type, ID length and payload length, or one ID/payload data byte.
// Output channel (o_valid / i_stall): one frame byte or error status per transfer,
// o_run_last marking the final result of an input item.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): CRC seed, applied at
// the next start; write it only while the block is idle.
// The first result of an item is formed by the sequencer from the input register
// and is captured in the result register, which drives the output channel.
// Throughput: one result per cycle while the output is not stalled; an item causes
// 1 to 7 results and holds the sequencer until its last one moves on, one CRC byte update per cycle.
// A new item is taken into the input register in the cycle that the last result
// of the previous one moves to the result register; single-result items flow
// back to back.
// Reset clears the frame state to idle and the CRC seed to 0xFFFF.
// A stall on the output holds the result register; the sequencer and then the
// input side back up behind it without loss.
module crc_framed_event_encoder #(
    parameter int MAX_ID_LEN      = crc_fe_pkg::DEF_MAX_ID_LEN,
    parameter int MAX_PAYLOAD_LEN = crc_fe_pkg::DEF_MAX_PAYLOAD_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    output logic        o_cfg_ready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_msg_type,
    input  logic [7:0]  i_reader_id_len,
    input  logic [15:0] i_pay_len,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic        o_frame_end,
    output logic        o_run_last
);
    import crc_fe_pkg::*;

    logic [15:0] r_seed;
    logic        r_in_valid;
    t_item       r_in;

    logic    consume;
    logic    adv;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_in_valid && !consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= CRC_SEED_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_seed <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in.command       <= i_command;
            r_in.msg_type      <= i_msg_type;
            r_in.reader_id_len <= i_reader_id_len;
            r_in.pay_len       <= i_pay_len;
            r_in.data_byte     <= i_data_byte;
        end
    end

    crc_fe_seq #(
        .MAX_ID_LEN      (MAX_ID_LEN),
        .MAX_PAYLOAD_LEN (MAX_PAYLOAD_LEN)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (r_seed),
        .i_item_valid (r_in_valid),
        .i_item       (r_in),
        .i_adv        (adv),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_consume    (consume)
    );

    crc_fe_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_stall     (i_stall),
        .o_adv       (adv),
        .o_valid     (o_valid),
        .o_res       (out_res)
    );

    assign o_out_byte  = out_res.out_byte;
    assign o_status    = out_res.status;
    assign o_frame_end = out_res.frame_end;
    assign o_run_last  = out_res.run_last;

    a_etx_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |->
            o_out_byte == FRAME_ETX && o_status == ST_FRAME && o_run_last)
        else $error("frame end not on a closing ETX");

    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_FRAME |->
            o_out_byte == 8'h00 && o_run_last && !o_frame_end)
        else $error("error result malformed");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && o_valid && i_stall |-> o_stall)
        else $error("input item released while output stalled");

endmodule

>>> src/crc_fe_seq.sv
module crc_fe_seq #(
    parameter int MAX_ID_LEN      = crc_fe_pkg::DEF_MAX_ID_LEN,
    parameter int MAX_PAYLOAD_LEN = crc_fe_pkg::DEF_MAX_PAYLOAD_LEN
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [15:0]          i_seed,
    input  logic                 i_item_valid,
    input  crc_fe_pkg::t_item    i_item,
    input  logic                 i_adv,
    output logic                 o_res_valid,
    output crc_fe_pkg::t_result  o_res,
    output logic                 o_consume
);
    import crc_fe_pkg::*;

    localparam int ID_W = $clog2(MAX_ID_LEN + 1);
    localparam int PL_W = $clog2(MAX_PAYLOAD_LEN + 1);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_ID      = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    localparam logic [3:0] K_STRAY = 4'd0;
    localparam logic [3:0] K_REJ   = 4'd1;
    localparam logic [3:0] K_STX   = 4'd2;
    localparam logic [3:0] K_LENLO = 4'd3;
    localparam logic [3:0] K_LENHI = 4'd4;
    localparam logic [3:0] K_IDLEN = 4'd5;
    localparam logic [3:0] K_DATA  = 4'd6;
    localparam logic [3:0] K_TYPE  = 4'd7;
    localparam logic [3:0] K_PLO   = 4'd8;
    localparam logic [3:0] K_PHI   = 4'd9;
    localparam logic [3:0] K_CRCLO = 4'd10;
    localparam logic [3:0] K_CRCHI = 4'd11;
    localparam logic [3:0] K_ETX   = 4'd12;

    logic [1:0]        r_phase;
    logic [ID_W-1:0]   r_id_left;
    logic [PL_W-1:0]   r_pay_left;
    logic [7:0]        r_held_type;
    logic [PL_W-1:0]   r_held_pl;
    logic [15:0]       r_crc;
    logic [STEP_W-1:0] r_step;

    logic [3:0]  kind;
    logic        last;
    logic        bad_start;
    logic        body;
    logic        fire;
    logic [15:0] frame_len;
    logic [15:0] held_pl16;

    assign bad_start = (i_item.reader_id_len == 8'd0)
                    || (i_item.reader_id_len > 8'(MAX_ID_LEN))
                    || (i_item.pay_len > 16'(MAX_PAYLOAD_LEN));
    assign frame_len = 16'(i_item.reader_id_len) + i_item.pay_len + LEN_OVERHEAD;
    assign held_pl16 = 16'(r_held_pl);

    always_comb begin
        kind = K_STRAY;
        last = 1'b1;
        if (i_item.command == CMD_START) begin
            if (bad_start) begin
                kind = K_REJ;
            end else begin
                unique case (r_step)
                    STEP_W'(0): begin kind = K_STX;   last = 1'b0; end
                    STEP_W'(1): begin kind = K_LENLO; last = 1'b0; end
                    STEP_W'(2): begin kind = K_LENHI; last = 1'b0; end
                    default:    begin kind = K_IDLEN; last = 1'b1; end
                endcase
            end
        end else begin
            unique case (r_phase)
                PH_ID: begin
                    unique case (r_step)
                        STEP_W'(0): begin kind = K_DATA;  last = (r_id_left != ID_W'(1)); end
                        STEP_W'(1): begin kind = K_TYPE;  last = 1'b0; end
                        STEP_W'(2): begin kind = K_PLO;   last = 1'b0; end
                        STEP_W'(3): begin kind = K_PHI;   last = (r_pay_left != '0); end
                        STEP_W'(4): begin kind = K_CRCLO; last = 1'b0; end
                        STEP_W'(5): begin kind = K_CRCHI; last = 1'b0; end
                        default:    begin kind = K_ETX;   last = 1'b1; end
                    endcase
                end
                PH_PAYLOAD: begin
                    unique case (r_step)
                        STEP_W'(0): begin kind = K_DATA;  last = (r_pay_left != PL_W'(1)); end
                        STEP_W'(1): begin kind = K_CRCLO; last = 1'b0; end
                        STEP_W'(2): begin kind = K_CRCHI; last = 1'b0; end
                        default:    begin kind = K_ETX;   last = 1'b1; end
                    endcase
                end
                default: begin
                    kind = K_STRAY;
                    last = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_res.status    = ST_FRAME;
        o_res.frame_end = 1'b0;
        o_res.run_last  = last;
        o_res.out_byte  = 8'h00;
        body            = 1'b0;
        unique case (kind)
            K_REJ:   o_res.status = ST_REJECT;
            K_STX:   o_res.out_byte = FRAME_STX;
            K_LENLO: o_res.out_byte = frame_len[7:0];
            K_LENHI: o_res.out_byte = frame_len[15:8];
            K_IDLEN: begin o_res.out_byte = i_item.reader_id_len; body = 1'b1; end
            K_DATA:  begin o_res.out_byte = i_item.data_byte;     body = 1'b1; end
            K_TYPE:  begin o_res.out_byte = r_held_type;          body = 1'b1; end
            K_PLO:   begin o_res.out_byte = held_pl16[7:0];       body = 1'b1; end
            K_PHI:   begin o_res.out_byte = held_pl16[15:8];      body = 1'b1; end
            K_CRCLO: o_res.out_byte = r_crc[7:0];
            K_CRCHI: o_res.out_byte = r_crc[15:8];
            K_ETX:   begin o_res.out_byte = FRAME_ETX; o_res.frame_end = 1'b1; end
            default: o_res.status = ST_STRAY;
        endcase
    end

    assign fire        = i_item_valid && i_adv;
    assign o_res_valid = i_item_valid;
    assign o_consume   = fire && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= '0;
            r_crc      <= CRC_SEED_RESET;
            r_phase    <= PH_IDLE;
            r_id_left  <= '0;
            r_pay_left <= '0;
        end else if (fire) begin
            r_step <= last ? '0 : r_step + STEP_W'(1);
            if (kind == K_STX) begin
                r_crc <= i_seed;
            end else if (body) begin
                r_crc <= crc_byte(r_crc, o_res.out_byte);
            end
            if (last) begin
                if (i_item.command == CMD_START) begin
                    if (bad_start) begin
                        r_phase    <= PH_IDLE;
                        r_id_left  <= '0;
                        r_pay_left <= '0;
                    end else begin
                        r_phase    <= PH_ID;
                        r_id_left  <= i_item.reader_id_len[ID_W-1:0];
                        r_pay_left <= i_item.pay_len[PL_W-1:0];
                    end
                end else if (r_phase == PH_ID) begin
                    r_id_left <= r_id_left - ID_W'(1);
                    if (r_id_left == ID_W'(1)) begin
                        r_phase <= (r_pay_left == '0) ? PH_IDLE : PH_PAYLOAD;
                    end
                end else if (r_phase == PH_PAYLOAD) begin
                    r_pay_left <= r_pay_left - PL_W'(1);
                    if (r_pay_left == PL_W'(1)) begin
                        r_phase <= PH_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && last && i_item.command == CMD_START && !bad_start) begin
            r_held_type <= i_item.msg_type;
            r_held_pl   <= i_item.pay_len[PL_W-1:0];
        end
    end

endmodule

>>> src/crc_fe_out.sv
module crc_fe_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_res_valid,
    input  crc_fe_pkg::t_result  i_res,
    input  logic                 i_stall,
    output logic                 o_adv,
    output logic                 o_valid,
    output crc_fe_pkg::t_result  o_res
);
    import crc_fe_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_adv   = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

>>> verif/crc_framed_event_encoder_tb.sv
`timescale 1ns / 100ps

module crc_framed_event_encoder_tb;
    import crc_fe_pkg::*;

    localparam logic [1:0] ENC_IDLE    = 2'd0;
    localparam logic [1:0] ENC_ID      = 2'd1;
    localparam logic [1:0] ENC_PAYLOAD = 2'd2;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_data = 16'h0000;
    logic        o_cfg_ready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_command = CMD_DATA;
    logic [7:0]  i_msg_type = 8'h00;
    logic [7:0]  i_reader_id_len = 8'h00;
    logic [15:0] i_pay_len = 16'h0000;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_status;
    logic        o_frame_end;
    logic        o_run_last;

    crc_framed_event_encoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_msg_type     (i_msg_type),
        .i_reader_id_len(i_reader_id_len),
        .i_pay_len      (i_pay_len),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_status       (o_status),
        .o_frame_end    (o_frame_end),
        .o_run_last     (o_run_last)
    );

    // encoder state as predicted
    logic [15:0] seed_reg = CRC_SEED_RESET;
    logic [1:0]  enc_phase = ENC_IDLE;
    int          id_left = 0;
    int          pay_left = 0;
    logic [7:0]  held_type = 8'h00;
    logic [15:0] held_plen = 16'h0000;
    logic [15:0] running_crc = CRC_SEED_RESET;

    t_result due_bytes[$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      src_idle_pct = 0;
    int      rcv_stall_pct = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic void emit(input logic [7:0] b, input logic [1:0] st, input logic fin);
        t_result r;
        r.out_byte  = b;
        r.status    = st;
        r.frame_end = fin;
        r.run_last  = 1'b0;
        due_bytes.push_back(r);
    endfunction

    function automatic void emit_body(input logic [7:0] b);
        running_crc = crc16_next(running_crc, b);
        emit(b, ST_FRAME, 1'b0);
    endfunction

    function automatic void emit_trailer();
        emit(running_crc[7:0], ST_FRAME, 1'b0);
        emit(running_crc[15:8], ST_FRAME, 1'b0);
        emit(FRAME_ETX, ST_FRAME, 1'b1);
        enc_phase = ENC_IDLE;
    endfunction

    // frame bytes or error results caused by one accepted transfer
    function automatic void encode_item(input t_item it);
        logic [15:0] flen;
        t_result     r;
        if (it.command == CMD_START) begin
            if (it.reader_id_len == 0 || it.reader_id_len > DEF_MAX_ID_LEN
                    || it.pay_len > DEF_MAX_PAYLOAD_LEN) begin
                enc_phase = ENC_IDLE;
                id_left   = 0;
                pay_left  = 0;
                emit(8'h00, ST_REJECT, 1'b0);
            end else begin
                flen        = 16'(it.reader_id_len + it.pay_len + LEN_OVERHEAD);
                held_type   = it.msg_type;
                held_plen   = it.pay_len;
                id_left     = int'(it.reader_id_len);
                pay_left    = int'(it.pay_len);
                running_crc = seed_reg;
                emit(FRAME_STX, ST_FRAME, 1'b0);
                emit(flen[7:0], ST_FRAME, 1'b0);
                emit(flen[15:8], ST_FRAME, 1'b0);
                emit_body(it.reader_id_len);
                enc_phase = ENC_ID;
            end
        end else if (enc_phase == ENC_ID) begin
            emit_body(it.data_byte);
            if (id_left > 0) id_left--;
            if (id_left == 0) begin
                emit_body(held_type);
                emit_body(held_plen[7:0]);
                emit_body(held_plen[15:8]);
                if (pay_left == 0) emit_trailer();
                else enc_phase = ENC_PAYLOAD;
            end
        end else if (enc_phase == ENC_PAYLOAD) begin
            emit_body(it.data_byte);
            if (pay_left > 0) pay_left--;
            if (pay_left == 0) emit_trailer();
        end else begin
            emit(8'h00, ST_STRAY, 1'b0);
        end
        r = due_bytes.pop_back();
        r.run_last = 1'b1;
        due_bytes.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.out_byte  = o_out_byte;
            got.status    = o_status;
            got.frame_end = o_frame_end;
            got.run_last  = o_run_last;
            if (due_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: byte %h status %0d end %b last %b",
                             got.out_byte, got.status, got.frame_end, got.run_last);
            end else begin
                want = due_bytes.pop_front();
                if (got.out_byte !== want.out_byte || got.status !== want.status
                        || got.frame_end !== want.frame_end
                        || got.run_last !== want.run_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                                 want.out_byte, want.status, want.frame_end, want.run_last,
                                 got.out_byte, got.status, got.frame_end, got.run_last);
                end
            end
        end
    end

    function automatic t_item start_item(input logic [7:0] typ, input logic [7:0] idl,
                                         input logic [15:0] pl);
        t_item it;
        it.command       = CMD_START;
        it.msg_type      = typ;
        it.reader_id_len = idl;
        it.pay_len       = pl;
        it.data_byte     = 8'($urandom);
        return it;
    endfunction

    function automatic t_item data_item(input logic [7:0] b);
        t_item it;
        it.command       = CMD_DATA;
        it.msg_type      = 8'($urandom);
        it.reader_id_len = 8'($urandom);
        it.pay_len       = 16'($urandom);
        it.data_byte     = b;
        return it;
    endfunction

    // valid is left high on return; callers that wait afterwards use settle
    task automatic send_item(input t_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_command       <= it.command;
        i_msg_type      <= it.msg_type;
        i_reader_id_len <= it.reader_id_len;
        i_pay_len       <= it.pay_len;
        i_data_byte     <= it.data_byte;
        do @(posedge i_clk); while (o_stall);
        encode_item(it);
        items_sent++;
    endtask

    task automatic send_frame(input int idl, input int pl, input logic [7:0] typ,
                              input int n_data);
        send_item(start_item(typ, 8'(idl), 16'(pl)));
        repeat (n_data) send_item(data_item(8'($urandom)));
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        wait (due_bytes.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_crc_seed(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        seed_reg = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_cases();
        src_idle_pct  = 0;
        rcv_stall_pct = 0;
        send_item(data_item(8'hFF));
        send_item(start_item(8'h00, 8'd0, 16'd0));
        send_item(start_item(8'h11, 8'd65, 16'd0));
        send_item(start_item(8'hFF, 8'd255, 16'hFFFF));
        send_item(start_item(8'h22, 8'd1, 16'd257));
        // empty payload: last ID byte closes the frame
        send_item(start_item(8'hFF, 8'd1, 16'd0));
        send_item(data_item(8'h00));
        // new start abandons the open frame
        send_frame(3, 2, 8'h5A, 1);
        send_item(start_item(8'h00, 8'd2, 16'd1));
        send_item(data_item(8'h00));
        send_item(data_item(8'hFF));
        send_item(data_item(8'h81));
        // rejected start drops the open frame, next byte is stray
        send_frame(2, 1, 8'h3C, 1);
        send_item(start_item(8'h44, 8'd64, 16'd300));
        send_item(data_item(8'hAA));
        send_item(start_item(8'h99, 8'd64, 16'd256));
        send_item(start_item(8'h99, 8'd0, 16'd256));
        settle();
    endtask

    task automatic test_longest_frame();
        src_idle_pct  = 30;
        rcv_stall_pct = 30;
        send_frame(DEF_MAX_ID_LEN, 0, 8'hC3, DEF_MAX_ID_LEN);
        settle();
    endtask

    task automatic test_paused_sender();
        src_idle_pct  = 0;
        rcv_stall_pct = 55;
        send_frame(2, 3, 8'h7E, 2);
        settle();
        repeat (3) send_item(data_item(8'($urandom)));
        settle();
    endtask

    task automatic test_traffic_phase(input logic [15:0] seed, input int src_pct,
                                      input int rcv_pct, input int n_items);
        int          first;
        int          idl;
        int          pl;
        int          pick;
        logic [63:0] raw;
        t_item       it;
        write_crc_seed(seed);
        src_idle_pct  = src_pct;
        rcv_stall_pct = rcv_pct;
        first = items_sent;
        while (items_sent - first < n_items) begin
            pick = $urandom_range(99);
            idl  = ($urandom_range(9) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
            pl   = ($urandom_range(9) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 5);
            if (pick < 75) begin
                send_frame(idl, pl, 8'($urandom), idl + pl);
            end else if (pick < 85) begin
                send_frame(idl, pl, 8'($urandom), $urandom_range(0, idl + pl - 1));
            end else begin
                raw = {$urandom, $urandom};
                it  = raw[$bits(t_item)-1:0];
                send_item(it);
            end
        end
        settle();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_longest_frame();
        test_paused_sender();
        test_traffic_phase(16'h0000, 0, 0, 4);
        test_traffic_phase(16'($urandom), 55, 0, 4);
        test_traffic_phase(16'hFFFF, 0, 55, 4);
        test_traffic_phase(16'h1D0F, 30, 30, 4);
        if (mismatches == 0 && due_bytes.size() == 0) begin
            $display("crc_framed_event_encoder_tb: PASS");
        end else begin
            $display("crc_framed_event_encoder_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("crc_framed_event_encoder_tb: FAIL");
        $finish;
    end

endmodule
